>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands with a clock and a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off while reset is high
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// implication checked in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

>>> src/pcca_pkg.sv
// ----------------------------------------------------------------------------
// pcca_pkg
// Types and constants shared by the combination lock modules.
// ----------------------------------------------------------------------------
package pcca_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int TIMER_WIDTH     = 8;
   localparam int DIGIT_WIDTH     = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEBOUNCE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAP      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RESTART  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CODE0    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CODE1    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CODE2    = 3'd5;

   localparam logic [TIMER_WIDTH-1:0] DEBOUNCE_RESET = 8'd2;
   localparam logic [TIMER_WIDTH-1:0] GAP_RESET      = 8'd13;
   localparam logic [TIMER_WIDTH-1:0] RESTART_RESET  = 8'd38;
   localparam logic [DIGIT_WIDTH-1:0] CODE0_RESET    = 4'd1;
   localparam logic [DIGIT_WIDTH-1:0] CODE1_RESET    = 4'd2;
   localparam logic [DIGIT_WIDTH-1:0] CODE2_RESET    = 4'd3;

   localparam logic [DIGIT_WIDTH-1:0] COUNT_MAX      = 4'd10;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_MAX      = 4'd9;

   typedef struct packed {
      logic button_low;
      logic presence_high;
   } req_type;

   typedef struct packed {
      logic                   armed;
      logic                   light_on;
      logic [1:0]             digit_position;
      logic [DIGIT_WIDTH-1:0] press_total;
   } rsp_type;

   typedef struct packed {
      logic [TIMER_WIDTH-1:0] debounce_scans;
      logic [TIMER_WIDTH-1:0] gap_scans;
      logic [TIMER_WIDTH-1:0] restart_scans;
      logic [DIGIT_WIDTH-1:0] code_first;
      logic [DIGIT_WIDTH-1:0] code_second;
      logic [DIGIT_WIDTH-1:0] code_third;
   } cfg_type;

   function automatic logic [DIGIT_WIDTH-1:0] code_digit(cfg_type cfg, int idx);
      logic [DIGIT_WIDTH-1:0] d;
      if (idx == 0) begin
         d = cfg.code_first;
      end else if (idx == 1) begin
         d = cfg.code_second;
      end else begin
         d = cfg.code_third;
      end
      return d;
   endfunction

endpackage

>>> src/pulse_count_code_alarm.sv
// ----------------------------------------------------------------------------
// pulse_count_code_alarm: push-button combination lock with presence light
// Requests pass the request register and the state update into the result
// register. One request per cycle sustained while the response is not stalled.
// Reset clears valid flags and lock state and loads config defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pulse_count_code_alarm
   import pcca_pkg::*;
#(
   parameter int CODE_LENGTH = 3
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type cfg;
   req_type req_ff;
   logic    s1_valid_ff, s1_valid_in;
   logic    out_valid_ff, out_valid_in;
   logic    advance;
   logic    load;

   assign csr_ready = 1'b1;

   pcca_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign advance      = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !advance;
   assign load         = req_valid && !req_stall;
   assign s1_valid_in  = load || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         req_ff <= req_payload;
      end
   end

   pcca_core #(
      .CODE_LENGTH (CODE_LENGTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (req_ff),
      .cfg     (cfg),
      .result  (rsp_payload)
   );

   assign rsp_valid = out_valid_ff;

   `ASSERT_IMPLY(a_stall_only_when_full, clock, reset, req_stall, rsp_valid && rsp_stall)
   `ASSERT_NEXT(a_request_reaches_output, clock, reset, s1_valid_ff && !rsp_stall, rsp_valid)
   `ASSERT_IMPLY(a_light_off_disarmed, clock, reset, rsp_valid && !rsp_payload.armed,
                 !rsp_payload.light_on)
   `ASSERT_IMPLY(a_count_saturates, clock, reset, rsp_valid,
                 rsp_payload.press_total <= COUNT_MAX)

endmodule

>>> src/pcca_csr.sv
// ----------------------------------------------------------------------------
// pcca_csr
// Configuration registers: timer reloads and the stored code digits.
// ----------------------------------------------------------------------------
module pcca_csr
   import pcca_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_DEBOUNCE: cfg_in.debounce_scans = csr_data;
            REG_GAP:      cfg_in.gap_scans      = csr_data;
            REG_RESTART:  cfg_in.restart_scans  = csr_data;
            REG_CODE0:    cfg_in.code_first     = csr_data[DIGIT_WIDTH-1:0];
            REG_CODE1:    cfg_in.code_second    = csr_data[DIGIT_WIDTH-1:0];
            REG_CODE2:    cfg_in.code_third     = csr_data[DIGIT_WIDTH-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_scans <= DEBOUNCE_RESET;
         cfg_ff.gap_scans      <= GAP_RESET;
         cfg_ff.restart_scans  <= RESTART_RESET;
         cfg_ff.code_first     <= CODE0_RESET;
         cfg_ff.code_second    <= CODE1_RESET;
         cfg_ff.code_third     <= CODE2_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/pcca_core.sv
// ----------------------------------------------------------------------------
// pcca_core
// Per-scan update of the press counter, timers, digits, armed flag and light,
// with the result register.
// ----------------------------------------------------------------------------
module pcca_core
   import pcca_pkg::*;
#(
   parameter int CODE_LENGTH = 3
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int PW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam logic [PW:0] CODE_LEN_W = (PW+1)'(CODE_LENGTH);

   logic [DIGIT_WIDTH-1:0] count_ff, count_in;
   logic [DIGIT_WIDTH-1:0] digits_ff [CODE_LENGTH];
   logic [DIGIT_WIDTH-1:0] digits_in [CODE_LENGTH];
   logic [PW-1:0]          pos_ff, pos_in;
   logic                   armed_ff, armed_in;
   logic                   pres_ff, pres_in;
   logic                   light_ff, light_in;
   logic [TIMER_WIDTH-1:0] deb_ff, deb_in;
   logic [TIMER_WIDTH-1:0] gap_ff, gap_in;
   logic [TIMER_WIDTH-1:0] rst_ff, rst_in;
   rsp_type                result_ff, result_in;

   logic [TIMER_WIDTH-1:0] deb_dec, gap_dec, rst_dec;
   logic                   press, match;
   logic [PW-1:0]          pos_base;
   logic [PW:0]            pos_inc;
   logic [PW+1:0]          pos_ext;

   always_comb begin
      deb_dec = (deb_ff != '0) ? deb_ff - 1'b1 : deb_ff;
      gap_dec = (gap_ff != '0) ? gap_ff - 1'b1 : gap_ff;
      rst_dec = (rst_ff != '0) ? rst_ff - 1'b1 : rst_ff;

      press = item.button_low && (deb_dec == '0);
      match = 1'b1;
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (digits_ff[i] != code_digit(cfg, i)) begin
            match = 1'b0;
         end
      end

      pos_base = (rst_dec == '0) ? '0 : pos_ff;
      pos_inc  = {1'b0, pos_base} + 1'b1;

      count_in  = count_ff;
      digits_in = digits_ff;
      pos_in    = pos_ff;
      armed_in  = armed_ff;
      pres_in   = pres_ff;
      light_in  = light_ff;
      deb_in    = deb_dec;
      gap_in    = gap_dec;
      rst_in    = rst_dec;

      if (press) begin
         if (count_ff < COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
         deb_in = cfg.debounce_scans;
         gap_in = cfg.gap_scans;
         rst_in = cfg.restart_scans;
      end else if (match) begin
         armed_in = !armed_ff;
         for (int i = 0; i < CODE_LENGTH; i++) begin
            digits_in[i] = '0;
         end
         if (armed_ff) begin
            light_in = 1'b0;
         end
      end else if (gap_dec == '0) begin
         pos_in = pos_base;
         if (count_ff > DIGIT_MAX) begin
            for (int i = 0; i < CODE_LENGTH; i++) begin
               digits_in[i] = '0;
            end
            pos_in   = '0;
            count_in = '0;
         end else if (count_ff != '0) begin
            for (int i = 0; i < CODE_LENGTH; i++) begin
               if (pos_base == PW'(i)) begin
                  digits_in[i] = count_ff;
               end
            end
            count_in = '0;
            pos_in   = (pos_inc >= CODE_LEN_W) ? '0 : pos_inc[PW-1:0];
         end
      end

      if (armed_in) begin
         if (!pres_ff && item.presence_high) begin
            pres_in  = 1'b1;
            light_in = 1'b1;
         end else if (pres_ff && !item.presence_high) begin
            pres_in  = 1'b0;
            light_in = 1'b0;
         end
      end

      pos_ext                  = {2'b00, pos_in};
      result_in.armed          = armed_in;
      result_in.light_on       = light_in;
      result_in.digit_position = pos_ext[1:0];
      result_in.press_total    = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
         armed_ff <= 1'b0;
         pres_ff  <= 1'b0;
         light_ff <= 1'b0;
         deb_ff   <= '0;
         gap_ff   <= '0;
         rst_ff   <= '0;
         for (int i = 0; i < CODE_LENGTH; i++) begin
            digits_ff[i] <= '0;
         end
      end else if (advance) begin
         count_ff  <= count_in;
         digits_ff <= digits_in;
         pos_ff    <= pos_in;
         armed_ff  <= armed_in;
         pres_ff   <= pres_in;
         light_ff  <= light_in;
         deb_ff    <= deb_in;
         gap_ff    <= gap_in;
         rst_ff    <= rst_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> sim/tb_pulse_count_code_alarm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_count_code_alarm
// Scan-level test of the push-button combination lock. A shadow copy of the
// lock state predicts the status of every scan request. Each response is
// checked field by field against that prediction, in order. The stimulus runs
// directed scan sequences first. It then makes code entries under several
// timer and code settings, with random stalls on both channels and one long
// response hold-off.
// ----------------------------------------------------------------------------
module tb_pulse_count_code_alarm;
   import pcca_pkg::*;

   localparam int DIGITS         = 3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 200;
   localparam int FLUSH_CYCLES   = 10;
   localparam int IDLE_SETTLE    = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_B = 3'd7;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   req_type                    req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   rsp_type                    rsp_payload;
   logic                       csr_valid   = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index   = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data    = '0;

   logic [TIMER_WIDTH-1:0] debounce_cfg = DEBOUNCE_RESET;
   logic [TIMER_WIDTH-1:0] gap_cfg      = GAP_RESET;
   logic [TIMER_WIDTH-1:0] restart_cfg  = RESTART_RESET;
   logic [DIGIT_WIDTH-1:0] code_cfg [DIGITS] = '{CODE0_RESET, CODE1_RESET, CODE2_RESET};

   logic [DIGIT_WIDTH-1:0] presses               = '0;
   logic [DIGIT_WIDTH-1:0] digits [DIGITS]       = '{default: '0};
   logic [1:0]             next_pos              = '0;
   logic                   armed_now             = 1'b0;
   logic                   presence_seen         = 1'b0;
   logic                   light_now             = 1'b0;
   logic [TIMER_WIDTH-1:0] debounce_left         = '0;
   logic [TIMER_WIDTH-1:0] gap_left              = '0;
   logic [TIMER_WIDTH-1:0] restart_left          = '0;

   rsp_type lock_status_q [$];
   rsp_type predicted;
   rsp_type wanted;
   int      mismatch_count = 0;
   int      scan_count     = 0;
   int      idle_cycles    = 0;
   int      hold_off_len   = 0;
   bit      quiet          = 1'b0;

   pulse_count_code_alarm dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #1 clock = ~clock;

   task automatic scan_lock(input req_type scan, output rsp_type status);
      logic code_hit;
      code_hit = 1'b1;
      if (debounce_left != 0) debounce_left--;
      if (gap_left != 0) gap_left--;
      if (restart_left != 0) restart_left--;
      for (int i = 0; i < DIGITS; i++)
         if (digits[i] != code_cfg[i]) code_hit = 1'b0;
      if (scan.button_low && debounce_left == 0) begin
         if (presses < COUNT_MAX) presses++;
         debounce_left = debounce_cfg;
         gap_left      = gap_cfg;
         restart_left  = restart_cfg;
      end else if (code_hit) begin
         armed_now = ~armed_now;
         digits    = '{default: '0};
         if (!armed_now) light_now = 1'b0;
      end else if (gap_left == 0) begin
         if (restart_left == 0) next_pos = '0;
         if (presses > DIGIT_MAX) begin
            digits   = '{default: '0};
            next_pos = '0;
            presses  = '0;
         end else if (presses != 0) begin
            digits[next_pos] = presses;
            presses          = '0;
            next_pos         = (next_pos == DIGITS - 1) ? 2'd0 : next_pos + 2'd1;
         end
      end
      if (armed_now) begin
         if (!presence_seen && scan.presence_high) begin
            presence_seen = 1'b1;
            light_now     = 1'b1;
         end else if (presence_seen && !scan.presence_high) begin
            presence_seen = 1'b0;
            light_now     = 1'b0;
         end
      end
      status.armed          = armed_now;
      status.light_on       = light_now;
      status.digit_position = next_pos;
      status.press_total    = presses;
   endtask

   task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lock_status_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: response with no request pending, expected none, actual %p",
                     $time, rsp_payload);
         end else begin
            wanted = lock_status_q.pop_front();
            check_field("armed", 4'(wanted.armed), 4'(rsp_payload.armed));
            check_field("light_on", 4'(wanted.light_on), 4'(rsp_payload.light_on));
            check_field("digit_position", 4'(wanted.digit_position),
                        4'(rsp_payload.digit_position));
            check_field("press_total", wanted.press_total, rsp_payload.press_total);
         end
      end
      if (!reset && req_valid && !req_stall) begin
         scan_lock(req_payload, predicted);
         lock_status_q.push_back(predicted);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("pulse_count_code_alarm test failed");
         $finish;
      end
   end

   // hold responses: a requested long hold-off first, otherwise short random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_len != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_len) @(posedge clock);
            hold_off_len = 0;
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_scan(input logic button, input logic presence);
      req_type scan;
      scan.button_low    = button;
      scan.presence_high = presence;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= scan;
      do @(posedge clock); while (req_stall);
      scan_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (lock_status_q.size() != 0);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_DEBOUNCE: debounce_cfg = value;
         REG_GAP:      gap_cfg      = value;
         REG_RESTART:  restart_cfg  = value;
         REG_CODE0:    code_cfg[0]  = value[DIGIT_WIDTH-1:0];
         REG_CODE1:    code_cfg[1]  = value[DIGIT_WIDTH-1:0];
         REG_CODE2:    code_cfg[2]  = value[DIGIT_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [TIMER_WIDTH-1:0] debounce_val, gap_val, restart_val,
                            input logic [DIGIT_WIDTH-1:0] first, second, third);
      logic [3:0] pad;
      wait_idle();
      write_reg(REG_DEBOUNCE, debounce_val);
      write_reg(REG_GAP, gap_val);
      write_reg(REG_RESTART, restart_val);
      // upper data bits must be dropped by the code registers
      pad = 4'($urandom);
      write_reg(REG_CODE0, {pad, first});
      pad = 4'($urandom);
      write_reg(REG_CODE1, {pad, second});
      pad = 4'($urandom);
      write_reg(REG_CODE2, {pad, third});
      csr_valid <= 1'b0;
   endtask

   task automatic press_digit(input int unsigned count);
      repeat (count) begin
         send_scan(1'b1, 1'($urandom_range(0, 1)));
         repeat (debounce_cfg > 0 ? debounce_cfg - 1 : 0)
            send_scan(1'b0, 1'($urandom_range(0, 1)));
      end
      repeat (gap_cfg + $urandom_range(0, 2)) send_scan(1'b0, 1'($urandom_range(0, 1)));
   endtask

   task automatic enter_code(input bit correct);
      for (int i = 0; i < DIGITS; i++)
         press_digit(correct ? code_cfg[i] : $urandom_range(0, 11));
      repeat ($urandom_range(1, 3)) send_scan(1'b0, 1'($urandom_range(0, 1)));
   endtask

   task automatic noise_burst(input int unsigned count);
      repeat (count) send_scan($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_reset_values();
      enter_code(1'b1);
   endtask

   task automatic test_scan_sequence();
      configure(8'd0, 8'd0, 8'hFF, 4'd1, 4'd2, 4'd3);
      send_scan(1'b1, 1'b0);
      send_scan(1'b0, 1'b0);
      repeat (2) send_scan(1'b1, 1'b0);
      send_scan(1'b0, 1'b1);
      repeat (3) send_scan(1'b1, 1'b1);
      send_scan(1'b0, 1'b0);
      send_scan(1'b0, 1'b1);
      send_scan(1'b0, 1'b0);
      // saturate the count past nine, then commit to clear the entry
      repeat (11) send_scan(1'b1, 1'b1);
      send_scan(1'b0, 1'b0);
   endtask

   task automatic test_code_entry();
      logic [TIMER_WIDTH-1:0] debounce_val, gap_val, restart_val;
      logic [DIGIT_WIDTH-1:0] first, second, third;
      int unsigned            phase_end, pick;
      repeat (4) begin
         debounce_val = 8'($urandom_range(0, 2));
         gap_val      = debounce_val + 8'($urandom_range(1, 4));
         restart_val  = $urandom_range(0, 1) ? gap_val + 8'($urandom_range(1, 30))
                                             : 8'($urandom_range(0, gap_val));
         first        = 4'($urandom_range(1, 9));
         second       = 4'($urandom_range(1, 9));
         third        = 4'($urandom_range(1, 9));
         configure(debounce_val, gap_val, restart_val, first, second, third);
         phase_end = scan_count + 70;
         while (scan_count < phase_end) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
               enter_code(1'b1);
            else if (pick < 17)
               enter_code(1'b0);
            else
               noise_burst($urandom_range(5, 15));
         end
      end
   endtask

   task automatic test_zero_code();
      // an all-zero code matches the cleared digits
      configure(8'd1, 8'd1, 8'd0, 4'd0, 4'd0, 4'd0);
      noise_burst(12);
      configure(8'd1, 8'd1, 8'd0, 4'd15, 4'd9, 4'd0);
      press_digit(9);
      noise_burst(8);
      wait_idle();
      write_reg(REG_SPARE_A, 8'hFF);
      write_reg(REG_SPARE_B, 8'h00);
      csr_valid <= 1'b0;
      noise_burst(12);
   endtask

   task automatic test_slow_timers();
      configure(8'hFF, 8'hFF, 8'd1, 4'd1, 4'd2, 4'd3);
      send_scan(1'b1, 1'b1);
      repeat (265) send_scan($urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_backpressure();
      configure(8'd1, 8'd3, 8'd20, 4'd2, 4'd1, 4'd4);
      hold_off_len = 150;
      noise_burst(60);
   endtask

   task automatic test_quiet_tail();
      int unsigned phase_end;
      quiet = 1'b1;
      configure(8'd1, 8'd2, 8'd9, 4'd3, 4'd1, 4'd2);
      phase_end = scan_count + 100;
      while (scan_count < phase_end)
         enter_code($urandom_range(0, 4) != 0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_scan_sequence();
      test_code_entry();
      test_zero_code();
      test_slow_timers();
      test_backpressure();
      test_quiet_tail();
      req_valid <= 1'b0;
      do @(posedge clock); while (lock_status_q.size() != 0);
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("pulse_count_code_alarm test passed");
      else
         $display("pulse_count_code_alarm test failed");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/pcca_pkg.sv
src/pcca_csr.sv
src/pcca_core.sv
src/pulse_count_code_alarm.sv
sim/tb_pulse_count_code_alarm.sv
